// ----- hw/rtl/brle_pkg.sv -----
// shared types and constants of the bit run length encoder
package brle_pkg;

  localparam int unsigned ByteBits = 8;
  localparam int unsigned CountW   = 7;
  localparam int unsigned RemW     = 4;

  localparam logic [CountW-1:0] MaxRun   = 7'd127;
  localparam logic [RemW-1:0]   FullByte = 4'd8;

  // command codes carried in the slave tuser
  localparam logic CmdEncode = 1'b0;
  localparam logic CmdFinish = 1'b1;

  // one emitted code
  typedef struct packed {
    logic              run_bit;
    logic [CountW-1:0] run_length;
    logic              last_of_item;
    logic              end_of_stream;
  } brle_result_t;

  // outcome of one step of the encoder
  typedef struct packed {
    logic                emit;
    logic                done;
    brle_result_t        result;
    logic                started;
    logic                cur_bit;
    logic [CountW-1:0]   run_count;
    logic [ByteBits-1:0] bits;
    logic [RemW-1:0]     rem;
  } brle_step_t;

endpackage

// ----- hw/rtl/brle_step.sv -----
// one step of the encoder: consumes held bits up to a run boundary or the run cap
module brle_step
  import brle_pkg::*;
(
  input  logic                cmd_i,
  input  logic [ByteBits-1:0] bits_i,
  input  logic [RemW-1:0]     rem_i,
  input  logic                started_i,
  input  logic                cur_bit_i,
  input  logic [CountW-1:0]   run_count_i,
  output brle_step_t          step_o
);

  logic              eff_cur;
  logic [CountW-1:0] eff_cnt;
  logic [RemW-1:0]   lead;
  logic              still;
  logic [CountW-1:0] room;
  logic [RemW-1:0]   take;
  logic [CountW-1:0] sum;
  logic [RemW-1:0]   left;
  logic [ByteBits-1:0] shifted;
  logic              all_eq;

  assign eff_cur = started_i ? cur_bit_i : bits_i[ByteBits-1];
  assign eff_cnt = started_i ? run_count_i : '0;

  // leading bits equal to the run value, among the bits still held
  always_comb begin
    lead  = '0;
    still = 1'b1;
    for (int i = 0; i < ByteBits; i++) begin
      if (still && (RemW'(i) < rem_i) && (bits_i[ByteBits-1-i] == eff_cur)) begin
        lead = lead + 1'b1;
      end else begin
        still = 1'b0;
      end
    end
  end

  assign room    = MaxRun - eff_cnt;
  assign take    = ({3'b000, lead} < room) ? lead : room[RemW-1:0];
  assign sum     = eff_cnt + {3'b000, take};
  assign left    = rem_i - take;
  assign shifted = bits_i << take;

  // the bits after the boundary all match: no further run ends in this byte
  always_comb begin
    all_eq = 1'b1;
    for (int i = 0; i < ByteBits; i++) begin
      if ((RemW'(i) < left) && (shifted[ByteBits-1-i] != shifted[ByteBits-1])) begin
        all_eq = 1'b0;
      end
    end
  end

  always_comb begin
    step_o = '0;
    step_o.bits = bits_i;
    step_o.rem  = rem_i;
    if (cmd_i == CmdFinish) begin
      step_o.emit                 = started_i;
      step_o.done                 = 1'b1;
      step_o.result.run_bit       = cur_bit_i;
      step_o.result.run_length    = run_count_i;
      step_o.result.last_of_item  = 1'b1;
      step_o.result.end_of_stream = 1'b1;
    end else if (take == rem_i) begin
      // whole remainder joins the pending run
      step_o.done      = 1'b1;
      step_o.started   = 1'b1;
      step_o.cur_bit   = eff_cur;
      step_o.run_count = sum;
    end else begin
      step_o.emit                = 1'b1;
      step_o.result.run_bit      = eff_cur;
      step_o.result.run_length   = sum;
      step_o.result.last_of_item = all_eq;
      step_o.started             = 1'b1;
      step_o.cur_bit             = shifted[ByteBits-1];
      if (all_eq) begin
        step_o.done      = 1'b1;
        step_o.run_count = {3'b000, left};
      end else begin
        step_o.run_count = '0;
        step_o.bits      = shifted;
        step_o.rem       = left;
      end
    end
  end

endmodule

// ----- hw/rtl/brle_out_reg.sv -----
// output register holding one code until the downstream transfer
module brle_out_reg
  import brle_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  brle_result_t result_i,
  input  logic         ready_i,
  output logic         free_o,
  output logic         valid_o,
  output brle_result_t result_o
);

  logic         valid_q, valid_d;
  brle_result_t result_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ----- hw/rtl/bit_run_length_encoder.sv -----
// top level of the bit run length encoder
//
// channel   dir  tdata                                  tuser          tlast
// s_axis    in   [7:0] data_byte                        command        -
// m_axis    out  [0] run_bit [7:1] run_length           end_of_stream  last_of_item
//                [15:8] code_byte
//
// one step per cycle from the input register into the output register, unless
// a step that emits finds the output register full; each step delivers at most
// one code, and the single output register holds one code per transfer
// the next byte is taken in the cycle the current one finishes
// reset (rst_ni low, asynchronous) empties both registers and clears the run
// a stalled master side holds the code and stalls any step that would emit a code
module bit_run_length_encoder
  import brle_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side, tdata: [7:0] data_byte; tuser: [0] command
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  // master side, tdata: [0] run_bit, [7:1] run_length, [15:8] code_byte
  // tuser: [0] end_of_stream; tlast: last_of_item
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  // input register: item in progress and the bits of it not yet consumed
  logic                in_valid_q, in_valid_d;
  logic                cmd_q;
  logic [ByteBits-1:0] bits_q;
  logic [RemW-1:0]     rem_q;

  // pending run
  logic              started_q;
  logic              cur_bit_q;
  logic [CountW-1:0] run_count_q;

  brle_step_t   step;
  brle_result_t out_result;
  logic         out_free;
  logic         step_en;
  logic         item_done;
  logic         s_accept;

  brle_step u_step (
    .cmd_i       (cmd_q),
    .bits_i      (bits_q),
    .rem_i       (rem_q),
    .started_i   (started_q),
    .cur_bit_i   (cur_bit_q),
    .run_count_i (run_count_q),
    .step_o      (step)
  );

  // a step that emits needs room in the output register
  assign step_en   = in_valid_q && (out_free || !step.emit);
  assign item_done = step_en && step.done;

  assign s_axis_tready_o = !in_valid_q || item_done;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = s_accept ? 1'b1 : (item_done ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      rem_q       <= '0;
      started_q   <= 1'b0;
      cur_bit_q   <= 1'b0;
      run_count_q <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (s_accept) begin
        rem_q <= FullByte;
      end else if (step_en) begin
        rem_q <= step.rem;
      end
      if (step_en) begin
        started_q   <= step.started;
        cur_bit_q   <= step.cur_bit;
        run_count_q <= step.run_count;
      end
    end
  end

  // byte payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q  <= s_axis_tuser_i;
      bits_q <= s_axis_tdata_i;
    end else if (step_en) begin
      bits_q <= step.bits;
    end
  end

  brle_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step_en && step.emit),
    .result_i (step.result),
    .ready_i  (m_axis_tready_i),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid_o),
    .result_o (out_result)
  );

  // code byte is the run bit over the length
  assign m_axis_tdata_o = {out_result.run_bit, out_result.run_length,
                           out_result.run_length, out_result.run_bit};
  assign m_axis_tuser_o = out_result.end_of_stream;
  assign m_axis_tlast_o = out_result.last_of_item;

  // no emitted run is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[7:1] != '0))
    else $error("empty run emitted");

  // an end of stream code closes its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("end of stream without last");

  // with no run pending the run state sits at its idle values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> ((run_count_q == '0) && !cur_bit_q))
    else $error("idle run state not clear");

  // an encode item in progress still holds bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && (cmd_q == CmdEncode)) |-> ((rem_q != '0) && (rem_q <= FullByte)))
    else $error("bit count out of range");

  // after a finish the run is cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_done && (cmd_q == CmdFinish)) |=> !started_q)
    else $error("finish left a run pending");

endmodule
